/* src/y2a_pkg.sv */
// Shared types and constants for the YCbCr to ABGR converter.
// No dependencies; used by every module under src.
package y2a_pkg;

    localparam int LANES = 4;

    // configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BUFFER_WIDTH = 2'd2;
    localparam logic [1:0] REG_IMAGE_BASE   = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] BYTE_MAX     = 8'hFF;

    typedef struct packed {
        logic [7:0] luma0;
        logic [7:0] luma1;
        logic [7:0] luma2;
        logic [7:0] luma3;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } in_t;

    typedef struct packed {
        logic [31:0] pixel0;
        logic [31:0] pixel1;
        logic [31:0] pixel2;
        logic [31:0] pixel3;
        logic [31:0] pixel_address;
        logic        frame_done;
    } out_t;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [11:0] buffer_width;
        logic [31:0] image_base;
    } cfg_t;

endpackage

/* src/y2a_lane.sv */
// One conversion lane: a luma sample plus shared chroma to one ABGR word.
// Depends on y2a_pkg.
module y2a_lane
    import y2a_pkg::*;
(
    input  logic [7:0]        luma,
    input  logic signed [7:0] cb,
    input  logic signed [7:0] cr,
    output logic [31:0]       abgr
);

    logic signed [10:0] y_w;
    logic signed [10:0] cb_w;
    logic signed [10:0] cr_w;
    logic signed [10:0] r_sum;
    logic signed [10:0] g_sum;
    logic signed [10:0] b_sum;
    logic [7:0]         r_byte;
    logic [7:0]         g_byte;
    logic [7:0]         b_byte;

    function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 0)
            res = 8'd0;
        else if (v > 11'sd255)
            res = BYTE_MAX;
        else
            res = v[7:0];
        return res;
    endfunction

    always_comb
    begin
        y_w  = signed'({3'b000, luma});
        cb_w = 11'(cb);
        cr_w = 11'(cr);
        // arithmetic shifts floor toward minus infinity
        r_sum = y_w + cr_w + (cr_w >>> 2) + (cr_w >>> 3) + (cr_w >>> 5);
        g_sum = y_w - ((cb_w >>> 2) + (cb_w >>> 4) + (cb_w >>> 5))
                    - ((cr_w >>> 1) + (cr_w >>> 3) + (cr_w >>> 4) + (cr_w >>> 5));
        b_sum = y_w + cb_w + (cb_w >>> 1) + (cb_w >>> 2) + (cb_w >>> 6);
        r_byte = clamp_byte(r_sum);
        g_byte = clamp_byte(g_sum);
        b_byte = clamp_byte(b_sum);
        abgr = {ALPHA_OPAQUE, b_byte, g_byte, r_byte};
    end

endmodule

/* src/y2a_addr.sv */
// Raster walker: column/row counters and word offset, gives each group's address.
// Depends on y2a_pkg.
module y2a_addr
    import y2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        advance,
    output logic [31:0] pixel_address,
    output logic        frame_done
);

    logic [11:0] column_reg, column_next;
    logic [11:0] row_reg, row_next;
    logic [24:0] offset_reg, offset_next;

    logic [12:0] col_step;
    logic [12:0] row_step;
    logic [24:0] offset_step;
    logic [11:0] pitch_gap;

    always_comb
    begin
        pixel_address = cfg.image_base + {5'b0, offset_reg, 2'b00};
        col_step      = {1'b0, column_reg} + 13'd4;
        row_step      = {1'b0, row_reg} + 13'd1;
        offset_step   = offset_reg + 25'd4;
        pitch_gap     = (cfg.buffer_width > cfg.frame_width) ?
                        (cfg.buffer_width - cfg.frame_width) : 12'd0;
        frame_done    = 1'b0;
        column_next   = col_step[11:0];
        row_next      = row_reg;
        offset_next   = offset_step;
        if (col_step >= {1'b0, cfg.frame_width})
        begin
            column_next = 12'd0;
            offset_next = offset_step + {13'd0, pitch_gap};
            row_next    = row_step[11:0];
            if (row_step >= {1'b0, cfg.frame_height})
            begin
                frame_done  = 1'b1;
                row_next    = 12'd0;
                offset_next = 25'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= 12'd0;
            row_reg    <= 12'd0;
            offset_reg <= 25'd0;
        end
        else if (advance)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            offset_reg <= offset_next;
        end
    end

endmodule

/* src/ycbcr_to_abgr_csc_core.sv */
// Top level of the YCbCr to ABGR converter: config registers, four lanes,
// raster address walker and the output register. Depends on y2a_pkg,
// y2a_lane and y2a_addr.
//
// Usage:
//   in_valid/in_ready/in_data carry one group: four luma samples of a row and
//   the Cb/Cr pair they share. out_valid/out_ready/out_data carry four ABGR
//   words, the byte address of the first word and a last-group-of-frame flag.
//   Write frame_width, frame_height, buffer_width and image_base through
//   cfg_write/cfg_index/cfg_data while no transaction is in flight.
// Timing:
//   Four lanes convert the pixels in parallel within the accept cycle; the
//   merged result lands in one output register; out_valid rises in the cycle
//   after the accept. While out_ready holds, one group per cycle is sustained.
//   in_ready is high while the output register is empty or being drained in
//   the same cycle, so a stalled receiver holds the result and back-pressures
//   the input after one buffered group.
// Reset:
//   rst_n clears the registers and raster counters to zero and empties the
//   output register.
module ycbcr_to_abgr_csc_core
    import y2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data
);

    cfg_t              cfg_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;
    logic              accept;
    logic [7:0]        luma_lane [LANES];
    logic [31:0]       word_lane [LANES];
    logic signed [7:0] cb;
    logic signed [7:0] cr;
    logic [31:0]       pixel_address;
    logic              frame_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[11:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[11:0];
                REG_BUFFER_WIDTH: cfg_reg.buffer_width <= cfg_data[11:0];
                REG_IMAGE_BASE:   cfg_reg.image_base   <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // x - 128 for a byte is the byte with its top bit flipped, read as signed
    assign cb = signed'({~in_data.chroma_blue[7], in_data.chroma_blue[6:0]});
    assign cr = signed'({~in_data.chroma_red[7], in_data.chroma_red[6:0]});

    assign luma_lane[0] = in_data.luma0;
    assign luma_lane[1] = in_data.luma1;
    assign luma_lane[2] = in_data.luma2;
    assign luma_lane[3] = in_data.luma3;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        y2a_lane u_lane (
            .luma (luma_lane[i]),
            .cb   (cb),
            .cr   (cr),
            .abgr (word_lane[i])
        );
    end

    y2a_addr u_addr (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .advance       (accept),
        .pixel_address (pixel_address),
        .frame_done    (frame_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.pixel0        <= word_lane[0];
            out_data_reg.pixel1        <= word_lane[1];
            out_data_reg.pixel2        <= word_lane[2];
            out_data_reg.pixel3        <= word_lane[3];
            out_data_reg.pixel_address <= pixel_address;
            out_data_reg.frame_done    <= frame_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* tb/ycbcr_to_abgr_csc_core_tb.sv */
// Self-checking testbench for ycbcr_to_abgr_csc_core: YCbCr groups in, ABGR words plus
// raster addresses out, checked against an in-bench color and address predictor.
// Depends on y2a_pkg and the RTL under src.
module ycbcr_to_abgr_csc_core_tb;
    import y2a_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        in_t  stim;
        bit   typed;
        out_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        out_data;

    // predictor copy of the registers and the raster walker
    logic [11:0] frm_width = '0;
    logic [11:0] frm_height = '0;
    logic [11:0] buf_width = '0;
    logic [31:0] img_base = '0;
    logic [11:0] col_cnt = '0;
    logic [11:0] row_cnt = '0;
    logic [24:0] word_ofs = '0;

    out_t     expected_groups[$];
    dir_row_t dir_rows[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       ready_run = 0;
    int       stall_run = 0;

    ycbcr_to_abgr_csc_core u_top (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ycbcr_to_abgr_csc_core verification failed");
            $finish;
        end
    end

    // receiver: ready stretches broken by short stalls, now and then a long one
    always @(posedge clk) begin
        if (ready_run > 0) begin
            ready_run--;
            out_ready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            out_ready <= 1'b0;
        end else begin
            ready_run = $urandom_range(0, 24);
            stall_run = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(0, 3);
            out_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] clamp_byte(input int v);
        if (v > 255)
            return BYTE_MAX;
        if (v < 0)
            return 8'h00;
        return v[7:0];
    endfunction

    // shift-add conversion; >>> on int floors negative values
    function automatic logic [31:0] abgr_word(input logic [7:0] luma, input int cb,
                                              input int cr);
        int y;
        int r;
        int g;
        int b;
        y = luma;
        r = y + cr + (cr >>> 2) + (cr >>> 3) + (cr >>> 5);
        g = y - ((cb >>> 2) + (cb >>> 4) + (cb >>> 5))
              - ((cr >>> 1) + (cr >>> 3) + (cr >>> 4) + (cr >>> 5));
        b = y + cb + (cb >>> 1) + (cb >>> 2) + (cb >>> 6);
        return {ALPHA_OPAQUE, clamp_byte(b), clamp_byte(g), clamp_byte(r)};
    endfunction

    function automatic out_t predict_group(input in_t grp);
        out_t        res;
        int          cb;
        int          cr;
        logic [12:0] next_col;
        logic [12:0] next_row;
        cb = grp.chroma_blue;
        cb = cb - 128;
        cr = grp.chroma_red;
        cr = cr - 128;
        res.pixel0 = abgr_word(grp.luma0, cb, cr);
        res.pixel1 = abgr_word(grp.luma1, cb, cr);
        res.pixel2 = abgr_word(grp.luma2, cb, cr);
        res.pixel3 = abgr_word(grp.luma3, cb, cr);
        res.pixel_address = img_base + {5'b0, word_ofs, 2'b00};
        res.frame_done = 1'b0;
        next_col = {1'b0, col_cnt} + 13'd4;
        word_ofs = word_ofs + 25'd4;
        if (next_col >= {1'b0, frm_width}) begin
            if (buf_width > frm_width)
                word_ofs = word_ofs + {13'b0, buf_width - frm_width};
            col_cnt = '0;
            next_row = {1'b0, row_cnt} + 13'd1;
            if (next_row >= {1'b0, frm_height}) begin
                res.frame_done = 1'b1;
                row_cnt = '0;
                word_ofs = '0;
            end else begin
                row_cnt = next_row[11:0];
            end
        end else begin
            col_cnt = next_col[11:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            default: return r[7:0];
        endcase
    endfunction

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: expected %h, got %h", fname, want, got);
        end
    endtask

    // transaction is taken at the posedge following a negedge that sees valid && ready
    always @(negedge clk) begin
        out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_groups.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing pending: %h", out_data);
            end else begin
                want = expected_groups.pop_front();
                compare_field("pixel0", want.pixel0, out_data.pixel0);
                compare_field("pixel1", want.pixel1, out_data.pixel1);
                compare_field("pixel2", want.pixel2, out_data.pixel2);
                compare_field("pixel3", want.pixel3, out_data.pixel3);
                compare_field("pixel_address", want.pixel_address, out_data.pixel_address);
                compare_field("frame_done", want.frame_done, out_data.frame_done);
            end
        end
    end

    task automatic add_row(input in_t stim, input bit typed, input out_t want);
        dir_row_t row;
        row.stim = stim;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // bursts of back-to-back groups separated by random gaps
    task automatic send_group(input in_t grp, input bit typed, input out_t want);
        int   gap;
        logic acc;
        out_t pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= grp;
        acc = 1'b0;
        while (!acc) begin
            @(negedge clk);
            acc = in_ready;
            @(posedge clk);
        end
        pred = predict_group(grp);
        expected_groups.push_back(typed ? want : pred);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_FRAME_WIDTH:  frm_width = val[11:0];
            REG_FRAME_HEIGHT: frm_height = val[11:0];
            REG_BUFFER_WIDTH: buf_width = val[11:0];
            REG_IMAGE_BASE:   img_base = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // unused upper bits of the 12-bit registers carry junk
    task automatic run_phase(input logic [11:0] w, input logic [11:0] h,
                             input logic [11:0] b, input logic [31:0] base,
                             input int count);
        settle();
        write_reg(REG_FRAME_WIDTH, ($urandom & 32'hFFFF_F000) | w);
        write_reg(REG_FRAME_HEIGHT, ($urandom & 32'hFFFF_F000) | h);
        write_reg(REG_BUFFER_WIDTH, ($urandom & 32'hFFFF_F000) | b);
        write_reg(REG_IMAGE_BASE, base);
        cfg_write <= 1'b0;
        repeat (count)
            send_group({rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                        rand_byte(), rand_byte()}, 1'b0, '0);
    endtask

    initial begin
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] b;

        // after reset every register is zero: each group is a whole frame at address 0
        add_row({8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80}, 1'b1,
                {32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000, 32'h0, 1'b1});
        add_row({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h80}, 1'b1,
                {32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b1});
        add_row({8'h01, 8'h02, 8'h04, 8'h08, 8'h80, 8'h80}, 1'b1,
                {32'hFF010101, 32'hFF020202, 32'hFF040404, 32'hFF080808, 32'h0, 1'b1});
        add_row({8'h10, 8'h20, 8'h40, 8'h80, 8'h80, 8'h80}, 1'b1,
                {32'hFF101010, 32'hFF202020, 32'hFF404040, 32'hFF808080, 32'h0, 1'b1});
        add_row({8'h7F, 8'hFE, 8'hFD, 8'hFB, 8'h80, 8'h80}, 1'b1,
                {32'hFF7F7F7F, 32'hFFFEFEFE, 32'hFFFDFDFD, 32'hFFFBFBFB, 32'h0, 1'b1});
        add_row({8'h55, 8'hAA, 8'hF7, 8'hEF, 8'h80, 8'h80}, 1'b1,
                {32'hFF555555, 32'hFFAAAAAA, 32'hFFF7F7F7, 32'hFFEFEFEF, 32'h0, 1'b1});
        // chroma extremes and values next to the bias, where floor shifts matter
        add_row({8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'h00}, 1'b0, '0);
        add_row({8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hFF}, 1'b0, '0);
        add_row({8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'hFF}, 1'b0, '0);
        add_row({8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF, 8'h00}, 1'b0, '0);
        add_row({8'h40, 8'hC0, 8'h20, 8'hE0, 8'h7F, 8'h81}, 1'b0, '0);
        add_row({8'h40, 8'hC0, 8'h20, 8'hE0, 8'h81, 8'h7F}, 1'b0, '0);
        add_row({8'h00, 8'hFF, 8'h40, 8'hC0, 8'h01, 8'hFE}, 1'b0, '0);
        add_row({8'h33, 8'hCC, 8'h0F, 8'hF0, 8'h55, 8'hAA}, 1'b0, '0);
        add_row({8'h33, 8'hCC, 8'h0F, 8'hF0, 8'hAA, 8'h55}, 1'b0, '0);
        add_row({8'hFF, 8'h00, 8'h80, 8'h01, 8'h80, 8'h00}, 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_group(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        run_phase(12'd8, 12'd3, 12'd12, 32'h0000_1000, 60);
        run_phase(12'd10, 12'd2, 12'd16, 32'hFFFF_FFF0, 60);  // ragged row, address wrap
        run_phase(12'd12, 12'd2, 12'd4, 32'h8000_0000, 60);   // pitch below width
        run_phase(12'd0, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 40);
        run_phase(12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 100);
        run_phase(12'd16, 12'd0, 12'd0, 32'h0, 50);
        run_phase(12'd4, 12'd1, 12'd4095, 32'h1234_5678, 50);
        repeat (8) begin
            w = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 8) * 4 : $urandom_range(0, 4095);
            h = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 4) : $urandom_range(0, 4095);
            b = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 48) : $urandom_range(0, 4095);
            run_phase(w[11:0], h[11:0], b[11:0], $urandom, 75);
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("ycbcr_to_abgr_csc_core verification clean");
        else
            $display("ycbcr_to_abgr_csc_core verification failed");
        $finish;
    end

endmodule

/* filelist.f */
src/y2a_pkg.sv
src/y2a_lane.sv
src/y2a_addr.sv
src/ycbcr_to_abgr_csc_core.sv
tb/ycbcr_to_abgr_csc_core_tb.sv
